[sv/aeu_pkg.sv]
// Shared types, codes and constants for the multi-turn encoder unwrap block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aeu_pkg;

  // Sensor resolution and field widths
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned CPR_W    = 13;
  localparam int unsigned NOISE_W  = 12;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned DELTA_W  = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CPR_W-1:0]   CPR_DEFAULT   = 13'd4096;
  localparam logic [CPR_W-1:0]   WRAP_DEFAULT  = 13'd2048;
  localparam logic [NOISE_W-1:0] NOISE_DEFAULT = 12'd1;

  // Stream widths: tdata rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = 48;  // raw_angle(12) + new_zero(32) + pad
  localparam int unsigned IN_USER_W  = 3;   // op(2) + read_ok(1)
  localparam int unsigned OUT_DATA_W = 64;  // total(32) + delta(14) + raw(12) + pad
  localparam int unsigned OUT_USER_W = 2;   // reading_ok + reference_valid

  // Operation codes
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_RESET  = 2'd1,
    OP_ZERO   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_REV  = 2'd0,
    CFG_WRAP_THRESHOLD  = 2'd1,
    CFG_NOISE_THRESHOLD = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                       op;
    logic [RAW_W-1:0]          raw_angle;
    logic                      read_ok;
    logic signed [TOTAL_W-1:0] new_zero;
  } item_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_count;
    logic signed [DELTA_W-1:0] last_delta;
    logic                      reading_ok;
    logic                      reference_valid;
    logic [RAW_W-1:0]          latest_raw;
  } result_t;

endpackage

[sv/aeu_in_stage.sv]
// Input register stage: captures one transaction from the slave side.
// Depends on aeu_pkg.
`timescale 1ns / 1ps

module aeu_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  aeu_pkg::item_t                  in_item,
  output logic                            held_valid,
  output aeu_pkg::item_t                  held_item,
  input  logic                            take
);
  import aeu_pkg::*;

  // Stage can load when empty or when its item leaves this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

[sv/aeu_core.sv]
// Unwrap and accumulate: configuration registers, tracking state and the
// combinational update for one item. Depends on aeu_pkg.
`timescale 1ns / 1ps

module aeu_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aeu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aeu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              take,
  input  aeu_pkg::item_t                    item,
  output aeu_pkg::result_t                  result
);
  import aeu_pkg::*;

  logic [CPR_W-1:0]          counts_per_rev;
  logic [CPR_W-1:0]          wrap_threshold;
  logic [NOISE_W-1:0]        noise_threshold;

  logic [TOTAL_W-1:0]        total_counts, total_counts_next;
  logic [RAW_W-1:0]          reference_raw, reference_raw_next;
  logic [RAW_W-1:0]          latest_sample, latest_sample_next;
  logic signed [DELTA_W-1:0] delta_seen, delta_seen_next;
  logic                      have_reference, have_reference_next;
  logic                      read_succeeded, read_succeeded_next;

  logic [CPR_W-1:0]          eff_cpr;
  logic [CPR_W-1:0]          eff_wrap;
  logic signed [DELTA_W:0]   diff;
  logic signed [DELTA_W:0]   wrap_s;
  logic signed [DELTA_W:0]   cpr_s;
  logic signed [DELTA_W:0]   unwrapped;
  logic [DELTA_W:0]          mag;
  logic                      big_enough;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev  <= CPR_DEFAULT;
      wrap_threshold  <= WRAP_DEFAULT;
      noise_threshold <= NOISE_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COUNTS_PER_REV:  counts_per_rev  <= cfg_data;
        CFG_WRAP_THRESHOLD:  wrap_threshold  <= cfg_data;
        CFG_NOISE_THRESHOLD: noise_threshold <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective revolution size and rollover threshold
  always_comb begin
    if (counts_per_rev == '0 || counts_per_rev > CPR_DEFAULT) begin
      eff_cpr = CPR_DEFAULT;
    end else begin
      eff_cpr = counts_per_rev;
    end
    if (wrap_threshold != '0 && wrap_threshold < eff_cpr) begin
      eff_wrap = wrap_threshold;
    end else begin
      eff_wrap = eff_cpr >> 1;
    end
  end

  // Delta from the reference, corrected by one revolution past the threshold
  always_comb begin
    diff   = $signed({3'b000, item.raw_angle}) - $signed({3'b000, reference_raw});
    wrap_s = $signed({2'b00, eff_wrap});
    cpr_s  = $signed({2'b00, eff_cpr});
    if (diff > wrap_s) begin
      unwrapped = diff - cpr_s;
    end else if (diff < -wrap_s) begin
      unwrapped = diff + cpr_s;
    end else begin
      unwrapped = diff;
    end
    mag        = unwrapped[DELTA_W] ? (DELTA_W+1)'(0) - unwrapped : unwrapped;
    big_enough = mag >= {3'b000, noise_threshold};
  end

  // Next state for the item in hand
  always_comb begin
    total_counts_next   = total_counts;
    reference_raw_next  = reference_raw;
    latest_sample_next  = latest_sample;
    delta_seen_next     = delta_seen;
    have_reference_next = have_reference;
    read_succeeded_next = read_succeeded;
    case (item.op)
      OP_UPDATE: begin
        if (!item.read_ok) begin
          read_succeeded_next = 1'b0;
          delta_seen_next     = '0;
        end else begin
          latest_sample_next  = item.raw_angle;
          read_succeeded_next = 1'b1;
          if (!have_reference) begin
            reference_raw_next  = item.raw_angle;
            delta_seen_next     = '0;
            have_reference_next = 1'b1;
          end else begin
            delta_seen_next = unwrapped[DELTA_W-1:0];
            if (big_enough) begin
              total_counts_next  = total_counts
                                 + {{(TOTAL_W-DELTA_W){unwrapped[DELTA_W-1]}},
                                    unwrapped[DELTA_W-1:0]};
              reference_raw_next = item.raw_angle;
            end
          end
        end
      end
      OP_RESET, OP_ZERO: begin
        total_counts_next   = item.new_zero;
        reference_raw_next  = '0;
        latest_sample_next  = '0;
        delta_seen_next     = '0;
        have_reference_next = 1'b0;
        read_succeeded_next = 1'b0;
        if (item.op == OP_ZERO && item.read_ok) begin
          reference_raw_next  = item.raw_angle;
          latest_sample_next  = item.raw_angle;
          have_reference_next = 1'b1;
          read_succeeded_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_counts   <= '0;
      reference_raw  <= '0;
      latest_sample  <= '0;
      delta_seen     <= '0;
      have_reference <= 1'b0;
      read_succeeded <= 1'b0;
    end else if (take) begin
      total_counts   <= total_counts_next;
      reference_raw  <= reference_raw_next;
      latest_sample  <= latest_sample_next;
      delta_seen     <= delta_seen_next;
      have_reference <= have_reference_next;
      read_succeeded <= read_succeeded_next;
    end
  end

  // Result shows the state after this item
  always_comb begin
    result.total_count     = total_counts_next;
    result.last_delta      = delta_seen_next;
    result.reading_ok      = read_succeeded_next;
    result.reference_valid = have_reference_next;
    result.latest_raw      = latest_sample_next;
  end

endmodule

[sv/aeu_out_skid.sv]
// Result register with a skid slot, so the core keeps going for one extra
// transaction while the master side stalls. Depends on aeu_pkg.
`timescale 1ns / 1ps

module aeu_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aeu_pkg::result_t  in_result,
  output logic              out_valid,
  input  logic              out_ready,
  output aeu_pkg::result_t  out_result
);
  import aeu_pkg::*;

  logic    skid_valid;
  result_t skid_result;
  logic    out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (in_valid) begin
        out_result <= in_result;
      end
    end else if (in_valid && in_ready) begin
      skid_result <= in_result;
    end
  end

endmodule

[sv/absolute_encoder_unwrap_accumulator_top.sv]
// Top level of the multi-turn absolute encoder unwrap accumulator.
// Depends on aeu_pkg, aeu_in_stage, aeu_core and aeu_out_skid.
//
//   Channel   Direction  Handshake              Contents
//   s_axis    in         tvalid/tready          one sample with op code
//   m_axis    out        tvalid/tready          one result per sample
//   cfg       in         cfg_we (no wait)       counts/rev, wrap and noise thresholds
//
// One transaction per clock is accepted and one result per clock is produced while
// the master side does not stall. The sample sits in the input register while the
// unwrap/accumulate logic settles, and its result is registered into the result
// register, or into the skid slot while the master side stalls, for m_axis.
// A master-side stall is absorbed by a one-entry skid slot; s_axis_tready drops
// only when the input register, the result register and the skid slot are all
// full, and after such a stall the core waits while the skid slot empties first.
// rst is synchronous; it restores the register defaults and clears the tracking state and all valid flags.
`timescale 1ns / 1ps

module absolute_encoder_unwrap_accumulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [aeu_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // raw_angle, new_zero
  input  logic [aeu_pkg::IN_USER_W-1:0]       s_axis_tuser,  // op, read_ok
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // total_count, last_delta, latest_raw
  output logic [aeu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [aeu_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // reading_ok, reference_valid
  input  logic                                cfg_we,
  input  logic [aeu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aeu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import aeu_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    skid_ready;
  result_t core_result;
  result_t out_result;

  // Unpack the slave-side transaction
  always_comb begin
    in_item.op        = op_t'(s_axis_tuser[1:0]);
    in_item.read_ok   = s_axis_tuser[2];
    in_item.raw_angle = s_axis_tdata[11:0];
    in_item.new_zero  = s_axis_tdata[43:12];
  end

  assign take = held_valid && skid_ready;

  aeu_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  aeu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (held_item),
    .result    (core_result)
  );

  aeu_out_skid u_out_skid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (held_valid),
    .in_ready   (skid_ready),
    .in_result  (core_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  // Pack the master-side transaction
  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[31:0]  = out_result.total_count;
    m_axis_tdata[45:32] = out_result.last_delta;
    m_axis_tdata[57:46] = out_result.latest_raw;
    m_axis_tuser[0]     = out_result.reading_ok;
    m_axis_tuser[1]     = out_result.reference_valid;
  end

endmodule

[tb/absolute_encoder_unwrap_accumulator_top_test.sv]
// Self-checking testbench for the multi-turn encoder unwrap accumulator.
// Depends on aeu_pkg and absolute_encoder_unwrap_accumulator_top; a scoreboard
// class predicts every result from the accepted samples and checks the stream.
`timescale 1ns / 1ps

// Predicts the unwrapped multi-turn count and holds the pending results
class unwrap_scoreboard;
  logic [aeu_pkg::CPR_W-1:0]   cpr_reg;
  logic [aeu_pkg::CPR_W-1:0]   wrap_reg;
  logic [aeu_pkg::NOISE_W-1:0] noise_reg;

  logic [aeu_pkg::TOTAL_W-1:0]        turn_total;
  logic [aeu_pkg::RAW_W-1:0]          ref_angle;
  logic [aeu_pkg::RAW_W-1:0]          last_angle;
  logic signed [aeu_pkg::DELTA_W-1:0] step_delta;
  bit                                 ref_held;
  bit                                 read_good;

  aeu_pkg::result_t pending_q[$];
  int mismatches;
  int compared;

  function new();
    cpr_reg    = aeu_pkg::CPR_DEFAULT;
    wrap_reg   = aeu_pkg::WRAP_DEFAULT;
    noise_reg  = aeu_pkg::NOISE_DEFAULT;
    mismatches = 0;
    compared   = 0;
    zero_state('0);
  endfunction

  function void zero_state(logic [aeu_pkg::TOTAL_W-1:0] zero);
    turn_total = zero;
    ref_angle  = '0;
    last_angle = '0;
    step_delta = '0;
    ref_held   = 1'b0;
    read_good  = 1'b0;
  endfunction

  function void write_reg(aeu_pkg::cfg_idx_t idx, logic [aeu_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      aeu_pkg::CFG_COUNTS_PER_REV:  cpr_reg   = val;
      aeu_pkg::CFG_WRAP_THRESHOLD:  wrap_reg  = val;
      aeu_pkg::CFG_NOISE_THRESHOLD: noise_reg = val[aeu_pkg::NOISE_W-1:0];
      default: ;  // unused index is dropped
    endcase
  endfunction

  // zero or oversized counts/rev fall back to the full sensor range
  function int rev_counts();
    if (cpr_reg == 0 || cpr_reg > aeu_pkg::CPR_DEFAULT)
      return int'(aeu_pkg::CPR_DEFAULT);
    return int'(cpr_reg);
  endfunction

  // wrap threshold must be nonzero and below counts/rev, else half a turn
  function int rollover_limit();
    int rev;
    rev = rev_counts();
    if (wrap_reg > 0 && int'(wrap_reg) < rev)
      return int'(wrap_reg);
    return rev / 2;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function void note_sample(aeu_pkg::item_t it);
    int d;
    int mag;
    aeu_pkg::result_t r;
    case (it.op)
      aeu_pkg::OP_UPDATE: begin
        if (!it.read_ok) begin
          read_good  = 1'b0;
          step_delta = '0;
        end else begin
          last_angle = it.raw_angle;
          read_good  = 1'b1;
          if (!ref_held) begin
            ref_angle  = it.raw_angle;
            step_delta = '0;
            ref_held   = 1'b1;
          end else begin
            d = int'(it.raw_angle) - int'(ref_angle);
            if (d > rollover_limit())
              d -= rev_counts();
            else if (d < -rollover_limit())
              d += rev_counts();
            mag = (d < 0) ? -d : d;
            step_delta = 14'(d);
            // small moves keep the old reference so they can build up
            if (mag >= int'(noise_reg)) begin
              turn_total = turn_total + 32'(d);
              ref_angle  = it.raw_angle;
            end
          end
        end
      end
      aeu_pkg::OP_RESET: zero_state(it.new_zero);
      aeu_pkg::OP_ZERO: begin
        zero_state(it.new_zero);
        if (it.read_ok) begin
          ref_angle  = it.raw_angle;
          last_angle = it.raw_angle;
          ref_held   = 1'b1;
          read_good  = 1'b1;
        end
      end
      default: ;  // unused op leaves the state alone
    endcase
    r.total_count     = turn_total;
    r.last_delta      = step_delta;
    r.reading_ok      = read_good;
    r.reference_valid = ref_held;
    r.latest_raw      = last_angle;
    pending_q.push_back(r);
  endfunction

  function void check_result(aeu_pkg::result_t got);
    aeu_pkg::result_t want;
    if (pending_q.size() == 0) begin
      $error("result transaction with nothing pending: total_count %0d", got.total_count);
      mismatches++;
      return;
    end
    want = pending_q.pop_front();
    compared++;
    if (got.total_count !== want.total_count) begin
      $error("total_count: expected %0d, actual %0d", want.total_count, got.total_count);
      mismatches++;
    end
    if (got.last_delta !== want.last_delta) begin
      $error("last_delta: expected %0d, actual %0d", want.last_delta, got.last_delta);
      mismatches++;
    end
    if (got.reading_ok !== want.reading_ok) begin
      $error("reading_ok: expected %0b, actual %0b", want.reading_ok, got.reading_ok);
      mismatches++;
    end
    if (got.reference_valid !== want.reference_valid) begin
      $error("reference_valid: expected %0b, actual %0b",
             want.reference_valid, got.reference_valid);
      mismatches++;
    end
    if (got.latest_raw !== want.latest_raw) begin
      $error("latest_raw: expected %0d, actual %0d", want.latest_raw, got.latest_raw);
      mismatches++;
    end
  endfunction
endclass

module absolute_encoder_unwrap_accumulator_top_test;
  import aeu_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_SAMPLES = 100;
  localparam int NUM_PHASES    = 7;
  localparam int DRAIN_CYCLES  = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // raw_angle, new_zero, pad
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // op, read_ok
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // total_count, last_delta, latest_raw, pad
  logic [OUT_USER_W-1:0] m_axis_tuser;        // reading_ok, reference_valid
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  unwrap_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int op_hits[4]    = '{0, 0, 0, 0};
  logic [RAW_W-1:0] angle_track = '0;

  // register settings per random phase: extremes and fallback cases
  logic [CFG_DATA_W-1:0] cpr_set[NUM_PHASES]   = '{13'd4096, 13'd0, 13'd1, 13'd8191,
                                                   13'd360, 13'd4095, 13'd2};
  logic [CFG_DATA_W-1:0] wrap_set[NUM_PHASES]  = '{13'd0, 13'd4096, 13'd1, 13'd100,
                                                   13'd100, 13'd4095, 13'd1};
  logic [CFG_DATA_W-1:0] noise_set[NUM_PHASES] = '{13'd0, 13'h1FFF, 13'd1, 13'd2,
                                                   13'd3, 13'd0, 13'd12};

  absolute_encoder_unwrap_accumulator_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted sample transactions feed the prediction
  always @(posedge clk) begin : sample_monitor
    item_t it;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      it.op        = op_t'(s_axis_tuser[1:0]);
      it.read_ok   = s_axis_tuser[2];
      it.raw_angle = s_axis_tdata[11:0];
      it.new_zero  = s_axis_tdata[43:12];
      op_hits[it.op]++;
      sb.note_sample(it);
    end
  end

  // accepted result transactions are checked in order
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.total_count     = m_axis_tdata[31:0];
      got.last_delta      = m_axis_tdata[45:32];
      got.latest_raw      = m_axis_tdata[57:46];
      got.reading_ok      = m_axis_tuser[0];
      got.reference_valid = m_axis_tuser[1];
      sb.check_result(got);
    end
  end

  function automatic item_t mk(op_t op, logic [RAW_W-1:0] raw, logic ok,
                               logic [TOTAL_W-1:0] zero);
    item_t it;
    it.op        = op;
    it.raw_angle = raw;
    it.read_ok   = ok;
    it.new_zero  = zero;
    return it;
  endfunction

  // mostly good updates that creep, jump or cross the wrap point
  function automatic item_t random_sample();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)      it.op = OP_UPDATE;
    else if (pick < 88) it.op = OP_ZERO;
    else if (pick < 95) it.op = OP_RESET;
    else                it.op = OP_NONE;
    it.read_ok = ($urandom_range(99) < 90);
    pick = $urandom_range(99);
    if (pick < 40)      it.raw_angle = angle_track + 12'($urandom_range(16)) - 12'd8;
    else if (pick < 70) it.raw_angle = angle_track + 12'($urandom_range(1200)) - 12'd600;
    else if (pick < 85) it.raw_angle = $urandom_range(1) ? 12'($urandom_range(15))
                                                         : 12'(4080 + $urandom_range(15));
    else                it.raw_angle = 12'($urandom);
    case ($urandom_range(3))
      0, 1: it.new_zero = $urandom;
      2:    it.new_zero = 32'h7FFF_FFF0 + 32'($urandom_range(31));
      default: it.new_zero = 32'($urandom_range(200)) - 32'd100;
    endcase
    if (it.read_ok)
      angle_track = it.raw_angle;
    return it;
  endfunction

  // called at a clock edge; returns at the edge that accepts the transaction
  task automatic send(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.new_zero, it.raw_angle};
    s_axis_tuser  <= {it.read_ok, it.op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(int ph);
    write_reg(CFG_UNUSED, 13'($urandom));
    write_reg(CFG_COUNTS_PER_REV, cpr_set[ph]);
    write_reg(CFG_WRAP_THRESHOLD, wrap_set[ph]);
    write_reg(CFG_NOISE_THRESHOLD, noise_set[ph]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int ph);
    if (ph < 2) begin
      send_idle_pct = 37;
      recv_idle_pct = 74;
    end else if (ph < 4) begin
      send_idle_pct = 74;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    item_t directed[$];

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    set_idling(0);
    directed.push_back(mk(OP_UPDATE, 12'd100, 1'b1, 32'd0));   // reference capture
    directed.push_back(mk(OP_UPDATE, 12'd100, 1'b1, 32'd0));   // below noise threshold
    directed.push_back(mk(OP_UPDATE, 12'd101, 1'b1, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'hFFF, 1'b0, 32'hFFFF_FFFF)); // failed read
    directed.push_back(mk(OP_UPDATE, 12'hFFF, 1'b1, 32'd0));   // backward rollover
    directed.push_back(mk(OP_UPDATE, 12'd5, 1'b1, 32'd0));     // forward rollover
    directed.push_back(mk(OP_UPDATE, 12'd2053, 1'b1, 32'd0));  // delta equals threshold
    directed.push_back(mk(OP_UPDATE, 12'd4, 1'b1, 32'd0));     // one past threshold
    directed.push_back(mk(OP_ZERO, 12'd0, 1'b1, 32'h7FFF_FFFF));
    directed.push_back(mk(OP_UPDATE, 12'hFFF, 1'b1, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'd0, 1'b1, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'd1, 1'b1, 32'd0));     // total wraps at 32 bits
    directed.push_back(mk(OP_ZERO, 12'd123, 1'b0, 32'h8000_0000)); // zero without capture
    directed.push_back(mk(OP_UPDATE, 12'd77, 1'b0, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'hFFF, 1'b1, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'd0, 1'b1, 32'd0));
    directed.push_back(mk(OP_RESET, 12'd0, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_NONE, 12'hFFF, 1'b1, 32'hFFFF_FFFF)); // unused op
    directed.push_back(mk(OP_UPDATE, 12'hAAA, 1'b1, 32'd0));
    directed.push_back(mk(OP_UPDATE, 12'h555, 1'b1, 32'd0));
    directed.push_back(mk(OP_ZERO, 12'hFFF, 1'b1, 32'd0));
    directed.push_back(mk(OP_RESET, 12'd0, 1'b0, 32'h5555_5555));
    directed.push_back(mk(OP_ZERO, 12'h555, 1'b1, 32'hAAAA_AAAA));
    foreach (directed[i])
      send(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain();

    // random phases, one register setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_idling(ph);
      program_regs(ph);
      if (ph == 4)
        hold_req++;  // long receiver hold-off while samples keep coming
      for (int n = 0; n < PHASE_SAMPLES; n++)
        send(random_sample());
      s_axis_tvalid <= 1'b0;
      drain();
    end

    $display("Covered %0d updates, %0d resets, %0d zero loads, %0d unused ops",
             op_hits[OP_UPDATE], op_hits[OP_RESET], op_hits[OP_ZERO], op_hits[OP_NONE]);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             NUM_PHASES + 1, sb.compared, sb.mismatches);
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
